// File: hw/rtl/elu_pkg.sv
// ----------------------------------------------------------------------------
// elu_pkg
// Shared types, constants and the exponent table generator for the ELU core.
// ----------------------------------------------------------------------------
package elu_pkg;

    localparam int DATA_W      = 16;
    // log2(e) in Q.14
    localparam int LOG2E_W     = 15;
    localparam logic [LOG2E_W-1:0] LOG2E_Q14 = 15'd23637;
    localparam int LOG2E_SHIFT = 14;
    localparam int PROD_W      = DATA_W + LOG2E_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam logic [SUM_W-1:0] ROUND_ADD = SUM_W'((1 << LOG2E_SHIFT) - 1);
    // width of the scaled exponent magnitude
    localparam int Q_W         = 16;
    // exponent shift at which exp(x) underflows to zero
    localparam int SHIFT_LIMIT = 16;
    localparam int SHIFT_W     = 4;

    typedef struct packed {
        logic                     pos;
        logic signed [DATA_W-1:0] sample;
        logic signed [DATA_W-1:0] grad;
    } elu_item_t;

    // round(2^frac * 2^(i / 2^tbits)), evaluated at elaboration only
    function automatic int elu_rom_entry(input int i, input int frac, input int tbits);
        real e;
        e = real'(frac) + real'(i) * (2.0 ** (-real'(tbits)));
        return $rtoi((2.0 ** e) + 0.5);
    endfunction

endpackage

// File: hw/rtl/elu_exp_arg.sv
// ----------------------------------------------------------------------------
// elu_exp_arg
// Two stages: scale -x by log2(e), then split into shift count and table index.
// ----------------------------------------------------------------------------
module elu_exp_arg
    import elu_pkg::*;
#(
    parameter int FRAC_BITS  = 12,
    parameter int TABLE_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  elu_item_t             in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output elu_item_t             out_item,
    output logic                  out_sat,
    output logic [SHIFT_W-1:0]    out_shift,
    output logic [TABLE_BITS-1:0] out_idx
);

    localparam int SH_W = Q_W - FRAC_BITS + 1;

    // stage 1
    logic              s1_valid_reg;
    logic              s1_ready;
    elu_item_t         s1_item_reg;
    logic [PROD_W-1:0] s1_prod_reg;
    logic [PROD_W-1:0] s1_prod_next;
    logic [DATA_W-1:0] mag;

    // stage 2
    logic                  s2_valid_reg;
    logic                  s2_ready;
    elu_item_t             s2_item_reg;
    logic                  s2_sat_reg;
    logic [SHIFT_W-1:0]    s2_shift_reg;
    logic [TABLE_BITS-1:0] s2_idx_reg;

    logic [SUM_W-1:0]      sum;
    logic [Q_W-1:0]        q;
    logic [FRAC_BITS-1:0]  r;
    logic [FRAC_BITS-1:0]  f;
    logic [SH_W-1:0]       sh_full;
    logic [TABLE_BITS-1:0] idx_next;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // magnitude of a non-positive sample, 0x8000 reads as 32768
    assign mag          = DATA_W'(-in_item.sample);
    assign s1_prod_next = PROD_W'(mag) * PROD_W'(LOG2E_Q14);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= in_valid;
        end
        if (s1_ready && in_valid) begin
            s1_item_reg <= in_item;
            s1_prod_reg <= s1_prod_next;
        end
    end

    // ceiling of the scaled magnitude, then floor split of the negated value
    assign sum     = SUM_W'(s1_prod_reg) + ROUND_ADD;
    assign q       = Q_W'(sum >> LOG2E_SHIFT);
    assign r       = q[FRAC_BITS-1:0];
    assign f       = FRAC_BITS'(-r);
    assign sh_full = SH_W'(q[Q_W-1:FRAC_BITS]) + SH_W'(r != '0);

    if (FRAC_BITS >= TABLE_BITS) begin : g_idx_trunc
        assign idx_next = f[FRAC_BITS-1 -: TABLE_BITS];
    end else begin : g_idx_pad
        assign idx_next = {f, {(TABLE_BITS - FRAC_BITS){1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_item_reg  <= s1_item_reg;
            s2_sat_reg   <= (sh_full >= SH_W'(SHIFT_LIMIT)) && (SH_W > SHIFT_W);
            s2_shift_reg <= SHIFT_W'(sh_full);
            s2_idx_reg   <= idx_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = s2_item_reg;
    assign out_sat   = s2_sat_reg;
    assign out_shift = s2_shift_reg;
    assign out_idx   = s2_idx_reg;

`ifndef SYNTHESIS
    // a zero sample must come out as exp(0): no shift, first table entry
    a_zero_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_ready && s1_valid_reg && s1_item_reg.sample == '0)
        |=> (!s2_sat_reg && s2_shift_reg == '0 && s2_idx_reg == '0))
        else $error("zero sample mapped to nonzero exponent");
`endif

endmodule

// File: hw/rtl/elu_exp_lut.sv
// ----------------------------------------------------------------------------
// elu_exp_lut
// Fractional power-of-two table lookup and underflow shift.
// ----------------------------------------------------------------------------
module elu_exp_lut
    import elu_pkg::*;
#(
    parameter int FRAC_BITS  = 12,
    parameter int TABLE_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  elu_item_t             in_item,
    input  logic                  in_sat,
    input  logic [SHIFT_W-1:0]    in_shift,
    input  logic [TABLE_BITS-1:0] in_idx,
    output logic                  out_valid,
    input  logic                  out_ready,
    output elu_item_t             out_item,
    output logic [FRAC_BITS:0]    out_exp
);

    localparam int ROM_DEPTH = 1 << TABLE_BITS;

    logic [FRAC_BITS:0] rom_tab [ROM_DEPTH];

    for (genvar i = 0; i < ROM_DEPTH; i++) begin : g_rom
        assign rom_tab[i] = (FRAC_BITS + 1)'(elu_rom_entry(i, FRAC_BITS, TABLE_BITS));
    end

    logic               valid_reg;
    elu_item_t          item_reg;
    logic [FRAC_BITS:0] exp_reg;
    logic [FRAC_BITS:0] exp_next;

    assign in_ready = !valid_reg || out_ready;
    assign exp_next = in_sat ? '0 : (rom_tab[in_idx] >> in_shift);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            item_reg <= in_item;
            exp_reg  <= exp_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_exp   = exp_reg;

`ifndef SYNTHESIS
    // underflowed exponent must read as zero
    a_sat_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_ready && in_valid && in_sat) |=> (exp_reg == '0))
        else $error("underflow did not give zero exponent");
`endif

endmodule

// File: hw/rtl/elu_grad.sv
// ----------------------------------------------------------------------------
// elu_grad
// Gradient multiply, activation select and the output register.
// ----------------------------------------------------------------------------
module elu_grad
    import elu_pkg::*;
#(
    parameter int FRAC_BITS = 12
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     grad_en,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  elu_item_t                in_item,
    input  logic [FRAC_BITS:0]       in_exp,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] out_act,
    output logic signed [DATA_W-1:0] out_grad
);

    localparam int MUL_W = DATA_W + FRAC_BITS + 2;

    // stage 4
    logic                     s4_valid_reg;
    logic                     s4_ready;
    logic                     s4_pos_reg;
    logic signed [DATA_W-1:0] s4_dy_reg;
    logic signed [DATA_W-1:0] s4_act_reg;
    logic signed [DATA_W-1:0] s4_act_next;
    logic signed [MUL_W-1:0]  s4_prod_reg;
    logic signed [MUL_W-1:0]  s4_prod_next;

    // stage 5
    logic                     s5_valid_reg;
    logic                     s5_ready;
    logic signed [DATA_W-1:0] s5_act_reg;
    logic signed [DATA_W-1:0] s5_grad_reg;
    logic signed [DATA_W-1:0] s5_grad_next;
    logic signed [MUL_W-1:0]  prod_shr;

    assign s5_ready = !s5_valid_reg || out_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign in_ready = s4_ready;

    assign s4_prod_next = MUL_W'(in_item.grad) * MUL_W'($signed({1'b0, in_exp}));
    assign s4_act_next  = in_item.pos ? in_item.sample
                                      : DATA_W'(in_exp) - DATA_W'(1 << FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (s4_ready) begin
            s4_valid_reg <= in_valid;
        end
        if (s4_ready && in_valid) begin
            s4_pos_reg  <= in_item.pos;
            s4_dy_reg   <= in_item.grad;
            s4_act_reg  <= s4_act_next;
            s4_prod_reg <= s4_prod_next;
        end
    end

    // arithmetic shift floors toward minus infinity
    assign prod_shr = s4_prod_reg >>> FRAC_BITS;

    always_comb begin
        if (!grad_en) begin
            s5_grad_next = '0;
        end else if (s4_pos_reg) begin
            s5_grad_next = s4_dy_reg;
        end else begin
            s5_grad_next = DATA_W'(prod_shr);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
        end else if (s5_ready) begin
            s5_valid_reg <= s4_valid_reg;
        end
        if (s5_ready && s4_valid_reg) begin
            s5_act_reg  <= s4_act_reg;
            s5_grad_reg <= s5_grad_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_act   = s5_act_reg;
    assign out_grad  = s5_grad_reg;

`ifndef SYNTHESIS
    // negative branch activation never drops below -1.0
    a_act_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (s4_ready && in_valid && !in_item.pos)
        |=> (s4_act_reg >= -DATA_W'(1 << FRAC_BITS)))
        else $error("activation below -1.0");
`endif

endmodule

// File: hw/rtl/elu_activation_forward_backward_core.sv
// ----------------------------------------------------------------------------
// elu_activation_forward_backward_core
// Path: input beat to output beat through the scale, split, table, multiply
// and output registers. Throughput: one beat per cycle while the output is
// drained; the fixed 5-stage pipeline with per-stage valid bits absorbs output
// stalls and fills bubbles. Reset: aresetn synchronous active low clears all
// valid bits and sets gradient_enable to 1; no clearing pass, the exponent table is constant.
// ----------------------------------------------------------------------------
module elu_activation_forward_backward_core
    import elu_pkg::*;
#(
    parameter int FRAC_BITS  = 12,
    parameter int TABLE_BITS = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_sample_in,
    input  logic signed [DATA_W-1:0] s_upstream_grad,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_activation,
    output logic signed [DATA_W-1:0] m_input_grad
);

    logic grad_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grad_en_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            grad_en_reg <= cfg_wr_data;
        end
    end

    elu_item_t             in_item;
    logic                  arg_valid;
    logic                  arg_ready;
    elu_item_t             arg_item;
    logic                  arg_sat;
    logic [SHIFT_W-1:0]    arg_shift;
    logic [TABLE_BITS-1:0] arg_idx;
    logic                  lut_valid;
    logic                  lut_ready;
    elu_item_t             lut_item;
    logic [FRAC_BITS:0]    lut_exp;

    assign in_item.pos    = !s_sample_in[DATA_W-1] && (s_sample_in != '0);
    assign in_item.sample = s_sample_in;
    assign in_item.grad   = s_upstream_grad;

    elu_exp_arg #(
        .FRAC_BITS  (FRAC_BITS),
        .TABLE_BITS (TABLE_BITS)
    ) u_arg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (in_item),
        .out_valid (arg_valid),
        .out_ready (arg_ready),
        .out_item  (arg_item),
        .out_sat   (arg_sat),
        .out_shift (arg_shift),
        .out_idx   (arg_idx)
    );

    elu_exp_lut #(
        .FRAC_BITS  (FRAC_BITS),
        .TABLE_BITS (TABLE_BITS)
    ) u_lut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (arg_valid),
        .in_ready  (arg_ready),
        .in_item   (arg_item),
        .in_sat    (arg_sat),
        .in_shift  (arg_shift),
        .in_idx    (arg_idx),
        .out_valid (lut_valid),
        .out_ready (lut_ready),
        .out_item  (lut_item),
        .out_exp   (lut_exp)
    );

    elu_grad #(
        .FRAC_BITS (FRAC_BITS)
    ) u_grad (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .grad_en   (grad_en_reg),
        .in_valid  (lut_valid),
        .in_ready  (lut_ready),
        .in_item   (lut_item),
        .in_exp    (lut_exp),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_act   (m_activation),
        .out_grad  (m_input_grad)
    );

`ifndef SYNTHESIS
    // with nothing waiting at the output every stage can take a beat
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");
`endif

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ELU forward/backward core. A short table of
// corner beats runs first, then random beats in phases that change the
// gradient enable and the idle mix on both channels. Every output beat is
// compared in order against the table result or a bit-exact ELU/gradient bench model.
// ----------------------------------------------------------------------------
module tb_top;
    import elu_pkg::*;

    localparam int FRAC_BITS   = 12;
    localparam int TABLE_BITS  = 8;
    localparam int ROM_SIZE    = 1 << TABLE_BITS;
    localparam int ONE         = 1 << FRAC_BITS;
    localparam int FRAC_MASK   = ONE - 1;
    localparam int LOG2E_Q     = 23637;
    localparam int LOG2E_FRAC  = 14;
    localparam int UNDERFLOW   = 16;
    // wide enough for (2v+1)^ROM_SIZE with v < 2^(FRAC_BITS+1)
    localparam int POW_W       = (FRAC_BITS + 3) << TABLE_BITS;
    localparam int RAND_ITEMS  = 265;
    localparam int DRAIN_CYC   = 12;
    localparam int HOLD_CYC    = 300;
    localparam longint LIMIT_NS = 3_000_000;

    typedef struct packed {
        logic signed [DATA_W-1:0] act;
        logic signed [DATA_W-1:0] grad;
    } elu_result_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] dy;
        bit                       known;
        logic signed [DATA_W-1:0] act;
        logic signed [DATA_W-1:0] grad;
    } stim_row_t;

    typedef struct packed {
        bit grad_en;
        int send_idle;
        int recv_stall;
        int hold;
    } phase_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic                     cfg_wr_data;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [DATA_W-1:0] s_sample_in;
    logic signed [DATA_W-1:0] s_upstream_grad;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_activation;
    logic signed [DATA_W-1:0] m_input_grad;

    int unsigned exp2_rom [ROM_SIZE];
    elu_result_t elu_out_q [$];
    elu_result_t want;
    bit          grad_en_model;
    int          send_idle_pct;
    int          recv_stall_pct;
    int unsigned ready_hold;
    int unsigned mismatch_count;

    elu_activation_forward_backward_core #(
        .FRAC_BITS  (FRAC_BITS),
        .TABLE_BITS (TABLE_BITS)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample_in     (s_sample_in),
        .s_upstream_grad (s_upstream_grad),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_activation    (m_activation),
        .m_input_grad    (m_input_grad)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // exact test of m^ROM_SIZE > 2^e, used to round the table entries
    function automatic bit pow_above(input int unsigned m, input int unsigned e);
        bit [POW_W-1:0] p;
        p = POW_W'(m);
        repeat (TABLE_BITS) p = p * p;
        return p > (POW_W'(1) << e);
    endfunction

    // exp(x) in Q.FRAC_BITS for x <= 0
    function automatic int unsigned exp_nonpos(input int x);
        longint q;
        longint sh;
        longint f;
        q  = (longint'(-x) * LOG2E_Q + (1 << LOG2E_FRAC) - 1) >> LOG2E_FRAC;
        sh = q >> FRAC_BITS;
        f  = q & FRAC_MASK;
        if (f != 0) begin
            sh = sh + 1;
            f  = ONE - f;
        end
        if (sh >= UNDERFLOW)
            return 0;
        return exp2_rom[(f >> (FRAC_BITS - TABLE_BITS)) & (ROM_SIZE - 1)] >> sh;
    endfunction

    function automatic elu_result_t elu_predict(input logic signed [DATA_W-1:0] x,
                                                input logic signed [DATA_W-1:0] dy,
                                                input bit grad_en);
        elu_result_t r;
        int unsigned ex;
        longint      prod;
        if (x > 0) begin
            r.act  = x;
            r.grad = dy;
        end else begin
            ex     = exp_nonpos(int'(x));
            prod   = longint'(dy) * longint'(ex);
            r.act  = DATA_W'(int'(ex) - ONE);
            // arithmetic shift floors toward minus infinity
            r.grad = DATA_W'(prod >>> FRAC_BITS);
        end
        if (!grad_en)
            r.grad = '0;
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] corner_value();
        case ($urandom_range(5))
            0:       return DATA_W'(0);
            1:       return DATA_W'(1);
            2:       return DATA_W'(-1);
            3:       return DATA_W'(32767);
            4:       return DATA_W'(-32768);
            default: return DATA_W'(2);
        endcase
    endfunction

    // biased toward the exponential branch, where the table and shifts matter
    function automatic logic signed [DATA_W-1:0] rand_sample();
        case ($urandom_range(9))
            0, 1, 2, 3: return DATA_W'($urandom);
            4, 5, 6:    return DATA_W'(-$urandom_range(3 * ONE, 0));
            7:          return DATA_W'(-$urandom_range(32768, 0));
            8:          return corner_value();
            default:    return DATA_W'($urandom_range(ONE, 1));
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_grad();
        if ($urandom_range(4) == 0)
            return corner_value();
        return DATA_W'($urandom);
    endfunction

    task automatic send_beat(input logic signed [DATA_W-1:0] x,
                             input logic signed [DATA_W-1:0] dy,
                             input bit known,
                             input elu_result_t known_res);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_sample_in     <= x;
        s_upstream_grad <= dy;
        do @(posedge aclk); while (!s_ready);
        elu_out_q.push_back(known ? known_res : elu_predict(x, dy, grad_en_model));
    endtask

    task automatic drain_outputs();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (elu_out_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    task automatic write_grad_enable(input bit value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        grad_en_model = value;
    endtask

    // result side: random stalls plus an optional long hold-off
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (ready_hold != 0) begin
                m_ready    <= 1'b0;
                ready_hold = ready_hold - 1;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (elu_out_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: output beat with none pending, activation %0d grad %0d",
                         $time, m_activation, m_input_grad);
            end else begin
                want = elu_out_q.pop_front();
                if (m_activation !== want.act) begin
                    mismatch_count++;
                    $display("%0t: activation mismatch: expected %0d, actual %0d",
                             $time, want.act, m_activation);
                end
                if (m_input_grad !== want.grad) begin
                    mismatch_count++;
                    $display("%0t: input_grad mismatch: expected %0d, actual %0d",
                             $time, want.grad, m_input_grad);
                end
            end
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        stim_row_t   dir_rows [$];
        phase_t      phases [$];
        elu_result_t none;
        int unsigned v;
        int unsigned e;

        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = 1'b0;
        s_valid         = 1'b0;
        s_sample_in     = '0;
        s_upstream_grad = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        ready_hold      = 0;
        mismatch_count  = 0;
        grad_en_model   = 1'b1;
        none            = '0;

        // round(2^FRAC_BITS * 2^(i/ROM_SIZE)), refined with exact integer powers
        for (int i = 0; i < ROM_SIZE; i++) begin
            v = $rtoi(real'(ONE) * (2.0 ** (real'(i) / real'(ROM_SIZE))) + 0.5);
            e = (FRAC_BITS + 1) * ROM_SIZE + i;
            while (!pow_above(2 * v + 1, e)) v++;
            while (v > 1 && pow_above(2 * v - 1, e)) v--;
            exp2_rom[i] = v;
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // x, dy, known, activation, input_grad (gradient enabled after reset)
        dir_rows = '{
            '{0,      1234,   1'b1, 0,      1234},
            '{0,      -32768, 1'b1, 0,      -32768},
            '{0,      32767,  1'b1, 0,      32767},
            '{0,      -1,     1'b1, 0,      -1},
            '{1,      -1,     1'b1, 1,      -1},
            '{32767,  -32768, 1'b1, 32767,  -32768},
            '{32767,  32767,  1'b1, 32767,  32767},
            '{4096,   0,      1'b1, 4096,   0},
            '{21845,  -21846, 1'b1, 21845,  -21846},
            '{-1,     100,    1'b0, 0,      0},
            '{-1,     -100,   1'b0, 0,      0},
            '{-1,     32767,  1'b0, 0,      0},
            '{-1,     -32768, 1'b0, 0,      0},
            '{-2,     1,      1'b0, 0,      0},
            '{-4096,  4096,   1'b0, 0,      0},
            '{-12288, 7,      1'b0, 0,      0},
            '{-100,   -12345, 1'b0, 0,      0},
            '{-21846, 21845,  1'b0, 0,      0},
            '{-32768, 32767,  1'b0, 0,      0},
            '{-32768, -32768, 1'b0, 0,      0},
            '{-32768, -1,     1'b0, 0,      0},
            '{-32768, 0,      1'b0, 0,      0}
        };

        foreach (dir_rows[i]) begin
            none.act  = dir_rows[i].act;
            none.grad = dir_rows[i].grad;
            send_beat(dir_rows[i].x, dir_rows[i].dy, dir_rows[i].known, none);
        end
        drain_outputs();
        none = '0;

        phases = '{
            '{1'b0, 0,  0,  0},
            '{1'b1, 66, 0,  0},
            '{1'b0, 0,  66, 0},
            '{1'b1, 14, 14, 0},
            '{1'b1, 0,  0,  HOLD_CYC},
            '{1'b0, 14, 14, 0}
        };

        foreach (phases[p]) begin
            write_grad_enable(phases[p].grad_en);
            send_idle_pct  = phases[p].send_idle;
            recv_stall_pct = phases[p].recv_stall;
            // long back-pressure so the pipeline fills and drops s_ready
            ready_hold     = phases[p].hold;
            repeat (RAND_ITEMS) send_beat(rand_sample(), rand_grad(), 1'b0, none);
            drain_outputs();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain_outputs();

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/elu_pkg.sv
hw/rtl/elu_exp_arg.sv
hw/rtl/elu_exp_lut.sv
hw/rtl/elu_grad.sv
hw/rtl/elu_activation_forward_backward_core.sv
verif/tb_top.sv
